### src/rac_pkg.sv
// ----------------------------------------------------------------------------
// rac_pkg: shared types and constants of the region access checker
// Status codes, opcodes, access kinds, and the command/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rac_pkg;

	localparam int REGION_COUNT_DEF = 16;

	localparam int ADDR_W = 32;
	localparam int PERM_W = 2;
	localparam int KIND_W = 2;
	localparam int INDEX_W = 4;

	localparam int PERM_READ_BIT = 0;
	localparam int PERM_WRITE_BIT = 1;

	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [KIND_W-1:0] KIND_READ = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ZERO_LENGTH = 2'd1,
		ST_NOT_RUNNING = 2'd2,
		ST_GUEST_FAULT = 2'd3
	} rac_status_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture a check item, restart the table walk
		logic wr_en;  // load one table entry from the input beat
		logic rd_en;  // issue the next table read of the walk
	} rac_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic running;   // runtime_running register
		logic len_zero;  // length on the input beat is zero
		logic hit;       // probed entry is used and wholly contains the range
		logic miss_end;  // last entry probed without a hit
		logic perm_ok;   // probed entry grants the needed permission
	} rac_sts_t;

endpackage

### src/rac_ram.sv
// ----------------------------------------------------------------------------
// rac_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/rac_datapath.sv
// ----------------------------------------------------------------------------
// rac_datapath: region table and range compare
// Holds the region table, the running flag and the captured check item, and
// compares one table entry per cycle against the access range.
// ----------------------------------------------------------------------------
module rac_datapath import rac_pkg::*; #(
	parameter int REGION_COUNT = REGION_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	input  logic [INDEX_W-1:0] region_index,
	input  logic [ADDR_W-1:0] region_base,
	input  logic [ADDR_W-1:0] region_size,
	input  logic              region_used,
	input  logic [PERM_W-1:0] region_perms,
	input  logic [ADDR_W-1:0] address,
	input  logic [ADDR_W-1:0] length,
	input  logic [KIND_W-1:0] access_kind,
	input  rac_cmd_t          cmd,
	output rac_sts_t          sts
);

	localparam int IW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
	localparam int CW = $clog2(REGION_COUNT + 1);
	localparam int XW = ((IW > INDEX_W) ? IW : INDEX_W) + 1;
	localparam int WW = 2 * ADDR_W + PERM_W;

	logic              running_q;
	logic [ADDR_W-1:0] lo_q;
	logic [ADDR_W:0]   hi_q;
	logic [KIND_W-1:0] kind_q;
	logic [CW-1:0]     cnt_q;
	logic              probe_s1;
	logic              last_s1;
	logic              vld_s1;
	logic [REGION_COUNT-1:0] valid_q;

	logic [XW-1:0]     idx_ext;
	logic              idx_in_range;
	logic [IW-1:0]     widx;
	logic              wr_go;
	logic              rd_go;
	logic [WW-1:0]     wr_word;
	logic [WW-1:0]     rd_word;
	logic [ADDR_W-1:0] ent_base;
	logic [ADDR_W-1:0] ent_size;
	logic [PERM_W-1:0] ent_rights;
	logic [ADDR_W:0]   ent_end;
	logic              contain;

	assign idx_ext = XW'(region_index);
	assign idx_in_range = idx_ext < XW'(REGION_COUNT);
	assign widx = idx_ext[IW-1:0];
	assign wr_go = cmd.wr_en && idx_in_range;
	assign rd_go = cmd.rd_en && (cnt_q != CW'(REGION_COUNT));
	assign wr_word = {region_perms, region_size, region_base};

	rac_ram #(
		.WIDTH(WW),
		.DEPTH(REGION_COUNT)
	) u_table (
		.clk  (clk),
		.we   (wr_go),
		.waddr(widx),
		.wdata(wr_word),
		.re   (rd_go),
		.raddr(cnt_q[IW-1:0]),
		.rdata(rd_word)
	);

	assign ent_base = rd_word[ADDR_W-1:0];
	assign ent_size = rd_word[2*ADDR_W-1:ADDR_W];
	assign ent_rights = rd_word[WW-1:2*ADDR_W];

	// ends at 33 bits so a region near the top of memory never wraps
	assign ent_end = {1'b0, ent_base} + {1'b0, ent_size};
	assign contain = vld_s1 && (lo_q >= ent_base) && (hi_q <= ent_end);

	always_comb begin
		sts = '0;
		sts.running = running_q;
		sts.len_zero = (length == '0);
		sts.hit = probe_s1 && contain;
		sts.miss_end = probe_s1 && last_s1 && !contain;
		case (kind_q)
			KIND_READ:  sts.perm_ok = ent_rights[PERM_READ_BIT];
			KIND_WRITE: sts.perm_ok = ent_rights[PERM_WRITE_BIT];
			default:    sts.perm_ok = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			valid_q <= '0;
			cnt_q <= '0;
			probe_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				running_q <= cfg_wr_data;
			end
			if (wr_go) begin
				valid_q[widx] <= region_used;
			end
			probe_s1 <= rd_go;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (rd_go) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q <= address;
			hi_q <= {1'b0, address} + {1'b0, length};
			kind_q <= access_kind;
		end
		last_s1 <= (cnt_q == CW'(REGION_COUNT - 1));
		vld_s1 <= valid_q[cnt_q[IW-1:0]];
	end

endmodule

### src/rac_controller.sv
// ----------------------------------------------------------------------------
// rac_controller: item sequencer
// Decodes each input beat, runs the table walk and owns the result register.
// ----------------------------------------------------------------------------
module rac_controller import rac_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     opcode,
	input  logic     out_stall,
	input  rac_sts_t sts,
	output rac_cmd_t cmd,
	output logic     in_stall,
	output logic     out_valid,
	output logic [1:0] status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_HOLD
	} state_t;

	state_t      state_q;
	logic        out_valid_q;
	rac_status_t status_q;
	rac_status_t pend_q;

	logic        done;
	rac_status_t code;
	logic        out_free;
	logic        emit;

	assign out_free = !out_valid_q || !out_stall;
	assign emit = out_free && (done || (state_q == S_HOLD));
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status = status_q;

	always_comb begin
		cmd = '0;
		done = 1'b0;
		code = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (opcode == OP_WRITE) begin
						cmd.wr_en = 1'b1;
						done = 1'b1;
						code = ST_OK;
					end else if (!sts.running) begin
						done = 1'b1;
						code = ST_NOT_RUNNING;
					end else if (sts.len_zero) begin
						done = 1'b1;
						code = ST_ZERO_LENGTH;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_WALK: begin
				cmd.rd_en = 1'b1;
				if (sts.hit) begin
					done = 1'b1;
					code = sts.perm_ok ? ST_OK : ST_GUEST_FAULT;
				end else if (sts.miss_end) begin
					done = 1'b1;
					code = ST_GUEST_FAULT;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			status_q <= ST_OK;
			pend_q <= ST_OK;
		end else begin
			if (out_valid_q && !out_stall && !emit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE, S_WALK: begin
					if (cmd.load) begin
						state_q <= S_WALK;
					end else if (done) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							status_q <= code;
							state_q <= S_IDLE;
						end else begin
							pend_q <= code;
							state_q <= S_HOLD;
						end
					end
				end
				S_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q <= pend_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### src/region_access_checker_unit.sv
// ----------------------------------------------------------------------------
// region_access_checker_unit: memory region permission checker
// Result: a region write, a check while not running, and a zero-length check
//   settle their status at acceptance; a region check walks the table from entry
//   0 up and settles at the first containing used entry, or with a guest fault
//   when none contains it. The status is then registered for the result beat.
// Flow: a region check holds off the next beat until its table walk ends; the
//   walk reads one entry per cycle from the single table read port. Other beats
//   settle without a walk. A finished result waits in the output register
//   while the next beat is taken; if that register is still full when the next
//   result is ready, the input stalls until the output beat is taken.
// Reset: arst_n clears the running flag, all region used flags and the
//   control state; table contents are unknown until written. No clearing pass.
// ----------------------------------------------------------------------------
module region_access_checker_unit import rac_pkg::*; #(
	parameter int REGION_COUNT = REGION_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration: runtime_running
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              opcode,
	input  logic [INDEX_W-1:0] region_index,
	input  logic [ADDR_W-1:0] region_base,
	input  logic [ADDR_W-1:0] region_size,
	input  logic              region_used,
	input  logic [PERM_W-1:0] region_perms,
	input  logic [ADDR_W-1:0] address,
	input  logic [ADDR_W-1:0] length,
	input  logic [KIND_W-1:0] access_kind,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status
);

	// Command and status bundles between the sequencer and the table datapath.
	rac_cmd_t cmd;
	rac_sts_t sts;

	// Sequencer: decode the beat, settle the early statuses (not running,
	// zero length, region write), run the walk, hold the result beat.
	rac_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.status   (status)
	);

	// Datapath: region table in RAM plus used flags in flops; the walk
	// probes entries in index order, so the first containing used entry
	// decides and its permission bits settle the status.
	rac_datapath #(
		.REGION_COUNT(REGION_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.region_index(region_index),
		.region_base (region_base),
		.region_size (region_size),
		.region_used (region_used),
		.region_perms(region_perms),
		.address     (address),
		.length      (length),
		.access_kind (access_kind),
		.cmd         (cmd),
		.sts         (sts)
	);

	// A table write never overlaps a walk read.
	a_no_wr_during_walk: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.rd_en))
		else $error("table write during walk");

	// The walk only starts on an accepted beat.
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (in_valid && !in_stall && opcode == OP_CHECK))
		else $error("walk started without an accepted check beat");

	// A check that needs the table holds off the next beat.
	a_walk_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == OP_CHECK && sts.running && !sts.len_zero)
		|=> in_stall)
		else $error("input taken during table walk");

	// A check while not running reports at once when the output is free.
	a_not_running_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == OP_CHECK && !sts.running &&
		 (!out_valid || !out_stall))
		|=> (out_valid && status == ST_NOT_RUNNING))
		else $error("not-running status missing");

endmodule
